// ----- design/awfmd_pkg.sv -----
package awfmd_pkg;

    localparam int DATA_W    = 32;
    localparam int MODE_W    = 5;
    localparam int DIV_STEPS = 2;

    localparam logic [MODE_W-1:0] MODE_AND  = 5'd0;
    localparam logic [MODE_W-1:0] MODE_OR   = 5'd1;
    localparam logic [MODE_W-1:0] MODE_XOR  = 5'd2;
    localparam logic [MODE_W-1:0] MODE_BIC  = 5'd3;
    localparam logic [MODE_W-1:0] MODE_ADD  = 5'd4;
    localparam logic [MODE_W-1:0] MODE_ADDC = 5'd5;
    localparam logic [MODE_W-1:0] MODE_SUB  = 5'd6;
    localparam logic [MODE_W-1:0] MODE_SUBB = 5'd7;
    localparam logic [MODE_W-1:0] MODE_RSB  = 5'd8;
    localparam logic [MODE_W-1:0] MODE_RSBB = 5'd9;
    localparam logic [MODE_W-1:0] MODE_LLS  = 5'd10;
    localparam logic [MODE_W-1:0] MODE_RLS  = 5'd11;
    localparam logic [MODE_W-1:0] MODE_ARS  = 5'd12;
    localparam logic [MODE_W-1:0] MODE_ROTL = 5'd13;
    localparam logic [MODE_W-1:0] MODE_ROTR = 5'd14;
    localparam logic [MODE_W-1:0] MODE_MUL  = 5'd15;
    localparam logic [MODE_W-1:0] MODE_SMUL = 5'd16;
    localparam logic [MODE_W-1:0] MODE_DIV  = 5'd17;
    localparam logic [MODE_W-1:0] MODE_SDIV = 5'd18;

    typedef struct packed {
        logic [DATA_W-1:0] res;
        logic [DATA_W-1:0] hi;
        logic              cy;
        logic              ov;
        logic              wr;
        logic              wh;
        logic              dz;
        logic              is_div;
        logic              neg_q;
        logic              neg_r;
    } t_side;

endpackage

// ----- design/awfmd_div.sv -----
module awfmd_div #(
    parameter int DATA_W    = awfmd_pkg::DATA_W,
    parameter int DIV_STEPS = awfmd_pkg::DIV_STEPS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [DATA_W-1:0]     i_dividend,
    input  logic [DATA_W-1:0]     i_divisor,
    input  awfmd_pkg::t_side      i_side,
    output logic                  o_valid,
    output logic [DATA_W-1:0]     o_quot,
    output logic [DATA_W-1:0]     o_rem,
    output awfmd_pkg::t_side      o_side
);
    import awfmd_pkg::*;

    localparam int NSTG = DATA_W / DIV_STEPS;

    for (genvar k = 0; k < NSTG; k++) begin : g_stg
        logic              r_vld;
        logic [DATA_W-1:0] r_rem;
        logic [DATA_W-1:0] r_quo;
        logic [DATA_W-1:0] r_dvs;
        t_side             r_side;
        logic              p_vld;
        logic [DATA_W-1:0] p_rem;
        logic [DATA_W-1:0] p_quo;
        logic [DATA_W-1:0] p_dvs;
        t_side             p_side;
        logic [DATA_W-1:0] n_rem;
        logic [DATA_W-1:0] n_quo;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rem  = '0;
            assign p_quo  = i_dividend;
            assign p_dvs  = i_divisor;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = g_stg[k-1].r_vld;
            assign p_rem  = g_stg[k-1].r_rem;
            assign p_quo  = g_stg[k-1].r_quo;
            assign p_dvs  = g_stg[k-1].r_dvs;
            assign p_side = g_stg[k-1].r_side;
        end

        always_comb begin
            logic [DATA_W:0] trial;
            logic [DATA_W:0] diff;
            n_rem = p_rem;
            n_quo = p_quo;
            for (int s = 0; s < DIV_STEPS; s++) begin
                trial = {n_rem, n_quo[DATA_W-1]};
                diff  = trial - {1'b0, p_dvs};
                if (!diff[DATA_W]) begin
                    n_rem = diff[DATA_W-1:0];
                    n_quo = {n_quo[DATA_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[DATA_W-1:0];
                    n_quo = {n_quo[DATA_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= p_vld;
            end
            if (i_en) begin
                r_rem  <= n_rem;
                r_quo  <= n_quo;
                r_dvs  <= p_dvs;
                r_side <= p_side;
            end
        end
    end

    assign o_valid = g_stg[NSTG-1].r_vld;
    assign o_quot  = g_stg[NSTG-1].r_quo;
    assign o_rem   = g_stg[NSTG-1].r_rem;
    assign o_side  = g_stg[NSTG-1].r_side;

endmodule

// ----- design/alu_with_flags_mul_div_unit.sv -----
// channel  | dir | fields (lsb first)                                          | bits
// s_axis   | in  | mode, operand_a, operand_b, carry_in, overflow_in, 0 pad   | 72
// m_axis   | out | result, high_result, carry_out, overflow_out,              | 72
//          |     |   writes_result, writes_high, divide_by_zero, 0 pad         |
// one item enters per cycle when the output register is empty or taken; each item passes stages a, b, c,
// the divider stages and the output stage; the divider retires DIV_STEPS quotient bits per stage
// i_rst_n clears all valid bits; payload registers are not reset
// the whole pipeline advances when the output register is empty or taken
module alu_with_flags_mul_div_unit #(
    parameter int DIV_STEPS = awfmd_pkg::DIV_STEPS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // mode, operand_a, operand_b, carry_in, overflow_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata   // result, high_result, carry_out, overflow_out,
                                       // writes_result, writes_high, divide_by_zero
);
    import awfmd_pkg::*;

    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // stage a: input register
    logic              r_a_vld;
    logic [MODE_W-1:0] r_a_mode;
    logic [DATA_W-1:0] r_a_a;
    logic [DATA_W-1:0] r_a_b;
    logic              r_a_cin;
    logic              r_a_oin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= s_axis_tvalid;
        end
        if (en) begin
            r_a_mode <= s_axis_tdata[4:0];
            r_a_a    <= s_axis_tdata[36:5];
            r_a_b    <= s_axis_tdata[68:37];
            r_a_cin  <= s_axis_tdata[69];
            r_a_oin  <= s_axis_tdata[70];
        end
    end

    // stage b: alu, multiplier, divider operand prep
    t_side             n_b_side;
    logic [DATA_W-1:0] n_b_dvd;
    logic [DATA_W-1:0] n_b_dvs;

    always_comb begin
        logic [DATA_W:0]     sum;
        logic [DATA_W-1:0]   sx;
        logic [DATA_W-1:0]   sy;
        logic [DATA_W-1:0]   syo;
        logic [DATA_W-1:0]   sy2;
        logic [DATA_W-1:0]   dif;
        logic [2*DATA_W-1:0] sh;
        logic                in_rng;
        logic                a31;
        logic                b31;
        a31    = r_a_a[DATA_W-1];
        b31    = r_a_b[DATA_W-1];
        in_rng = (r_a_b[DATA_W-1:6] == '0);
        sum = {1'b0, r_a_a} + {1'b0, r_a_b}
              + {{DATA_W{1'b0}}, (r_a_mode == MODE_ADDC) && r_a_cin};
        if (r_a_mode == MODE_RSB || r_a_mode == MODE_RSBB) begin
            sx  = r_a_b;
            syo = r_a_a;
        end else begin
            sx  = r_a_a;
            syo = r_a_b;
        end
        sy2 = syo + {{(DATA_W-1){1'b0}}, r_a_cin};
        sy  = (r_a_mode == MODE_SUBB || r_a_mode == MODE_RSBB) ? sy2 : syo;
        dif = sx - sy;
        sh  = '0;

        n_b_side        = '0;
        n_b_side.wr     = 1'b1;
        n_b_dvd         = r_a_a;
        n_b_dvs         = r_a_b;
        unique case (r_a_mode)
            MODE_AND: n_b_side.res = r_a_a & r_a_b;
            MODE_OR:  n_b_side.res = r_a_a | r_a_b;
            MODE_XOR: n_b_side.res = r_a_a ^ r_a_b;
            MODE_BIC: n_b_side.res = r_a_a & ~r_a_b;
            MODE_ADD, MODE_ADDC: begin
                n_b_side.res = sum[DATA_W-1:0];
                n_b_side.cy  = sum[DATA_W];
                n_b_side.ov  = (a31 == b31) ? (sum[DATA_W-1] != b31) : r_a_oin;
            end
            MODE_SUB, MODE_SUBB, MODE_RSB, MODE_RSBB: begin
                n_b_side.res = dif;
                n_b_side.cy  = sx < sy;
                n_b_side.ov  = (sx[DATA_W-1] != syo[DATA_W-1])
                               ? (dif[DATA_W-1] != sx[DATA_W-1]) : r_a_oin;
            end
            MODE_LLS: begin
                sh = {{DATA_W{1'b0}}, r_a_a} << r_a_b[5:0];
                if (in_rng) begin
                    n_b_side.res = sh[DATA_W-1:0];
                    n_b_side.cy  = sh[DATA_W];
                end
            end
            MODE_RLS: begin
                sh = {{(DATA_W-1){1'b0}}, r_a_a, 1'b0} >> r_a_b[5:0];
                if (in_rng) begin
                    n_b_side.res = sh[DATA_W:1];
                    n_b_side.cy  = sh[0];
                end
            end
            MODE_ARS: begin
                sh = $unsigned($signed({{(DATA_W-1){a31}}, r_a_a, 1'b0}) >>> r_a_b[5:0]);
                if (in_rng) begin
                    n_b_side.res = sh[DATA_W:1];
                    n_b_side.cy  = sh[0];
                end else begin
                    n_b_side.res = {DATA_W{a31}};
                    n_b_side.cy  = a31;
                end
            end
            MODE_ROTL: begin
                sh = {r_a_a, r_a_a} << r_a_b[4:0];
                n_b_side.res = sh[2*DATA_W-1:DATA_W];
            end
            MODE_ROTR: begin
                sh = {r_a_a, r_a_a} >> r_a_b[4:0];
                n_b_side.res = sh[DATA_W-1:0];
            end
            MODE_MUL, MODE_SMUL: n_b_side.wh = 1'b1;
            MODE_DIV, MODE_SDIV: begin
                n_b_side.is_div = 1'b1;
                if (r_a_b == '0) begin
                    n_b_side.wr = 1'b0;
                    n_b_side.dz = 1'b1;
                end else begin
                    n_b_side.wh = 1'b1;
                end
                if (r_a_mode == MODE_SDIV) begin
                    n_b_side.neg_q = a31 ^ b31;
                    n_b_side.neg_r = a31;
                    n_b_dvd = a31 ? (~r_a_a + DATA_W'(1)) : r_a_a;
                    n_b_dvs = b31 ? (~r_a_b + DATA_W'(1)) : r_a_b;
                end
            end
            default: begin
                n_b_side.wr = 1'b0;
                n_b_side.cy = r_a_cin;
                n_b_side.ov = r_a_oin;
            end
        endcase
    end

    logic                r_b_vld;
    t_side               r_b_side;
    logic [DATA_W-1:0]   r_b_dvd;
    logic [DATA_W-1:0]   r_b_dvs;
    logic [2*DATA_W-1:0] r_b_prod;
    logic [DATA_W-1:0]   r_b_cor_a;
    logic [DATA_W-1:0]   r_b_cor_b;
    logic                r_b_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
        if (en) begin
            r_b_side  <= n_b_side;
            r_b_dvd   <= n_b_dvd;
            r_b_dvs   <= n_b_dvs;
            r_b_prod  <= {{DATA_W{1'b0}}, r_a_a} * {{DATA_W{1'b0}}, r_a_b};
            r_b_cor_a <= (r_a_mode == MODE_SMUL && r_a_b[DATA_W-1]) ? r_a_a : '0;
            r_b_cor_b <= (r_a_mode == MODE_SMUL && r_a_a[DATA_W-1]) ? r_a_b : '0;
            r_b_mul   <= (r_a_mode == MODE_MUL || r_a_mode == MODE_SMUL);
        end
    end

    // stage c: signed product correction
    t_side n_c_side;

    always_comb begin
        n_c_side = r_b_side;
        if (r_b_mul) begin
            n_c_side.res = r_b_prod[DATA_W-1:0];
            n_c_side.hi  = r_b_prod[2*DATA_W-1:DATA_W] - r_b_cor_a - r_b_cor_b;
        end
    end

    logic              r_c_vld;
    t_side             r_c_side;
    logic [DATA_W-1:0] r_c_dvd;
    logic [DATA_W-1:0] r_c_dvs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
        if (en) begin
            r_c_side <= n_c_side;
            r_c_dvd  <= r_b_dvd;
            r_c_dvs  <= r_b_dvs;
        end
    end

    // divider stages
    logic              d_vld;
    logic [DATA_W-1:0] d_quot;
    logic [DATA_W-1:0] d_rem;
    t_side             d_side;

    awfmd_div #(
        .DATA_W    (DATA_W),
        .DIV_STEPS (DIV_STEPS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_c_vld),
        .i_dividend (r_c_dvd),
        .i_divisor  (r_c_dvs),
        .i_side     (r_c_side),
        .o_valid    (d_vld),
        .o_quot     (d_quot),
        .o_rem      (d_rem),
        .o_side     (d_side)
    );

    // output stage: quotient and remainder sign fix and result select
    t_side n_o;

    always_comb begin
        n_o = d_side;
        if (d_side.is_div && !d_side.dz) begin
            n_o.res = d_side.neg_q ? (~d_quot + DATA_W'(1)) : d_quot;
            n_o.hi  = d_side.neg_r ? (~d_rem + DATA_W'(1)) : d_rem;
        end
    end

    logic  r_o_vld;
    t_side r_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= d_vld;
        end
        if (en) begin
            r_o <= n_o;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = {3'b000, r_o.dz, r_o.wh, r_o.wr, r_o.ov, r_o.cy, r_o.hi, r_o.res};

endmodule

// ----- verif/alu_with_flags_mul_div_unit_test.sv -----
module alu_with_flags_mul_div_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import awfmd_pkg::*;

    typedef struct packed {
        logic [4:0]  mode;
        logic [31:0] a;
        logic [31:0] b;
        logic        cin;
        logic        oin;
    } t_op;

    typedef struct packed {
        logic [31:0] res;
        logic [31:0] hi;
        logic        cy;
        logic        ov;
        logic        wr;
        logic        wh;
        logic        dz;
    } t_res;

    class alu_scoreboard;
        t_res pending[$];
        int   errors;
        int   checked;

        function t_res compute(t_op op);
            t_res        r;
            logic [63:0] t;
            logic [31:0] x, y, yo, s, ma, mb, q, rm;
            logic        use_sub;
            r = '0;
            r.wr = 1'b1;
            use_sub = 1'b0;
            x = '0;
            y = '0;
            yo = '0;
            case (op.mode)
                MODE_AND: r.res = op.a & op.b;
                MODE_OR:  r.res = op.a | op.b;
                MODE_XOR: r.res = op.a ^ op.b;
                MODE_BIC: r.res = op.a & ~op.b;
                MODE_ADD, MODE_ADDC: begin
                    t = {32'd0, op.a} + {32'd0, op.b}
                        + ((op.mode == MODE_ADDC) ? {63'd0, op.cin} : 64'd0);
                    r.res = t[31:0];
                    r.cy = t[32];
                    if (op.a[31] == op.b[31]) r.ov = r.res[31] != op.b[31];
                    else r.ov = op.oin;
                end
                MODE_SUB: begin
                    use_sub = 1; x = op.a; y = op.b; yo = op.b;
                end
                MODE_SUBB: begin
                    use_sub = 1; x = op.a; y = op.b + op.cin; yo = op.b;
                end
                MODE_RSB: begin
                    use_sub = 1; x = op.b; y = op.a; yo = op.a;
                end
                MODE_RSBB: begin
                    use_sub = 1; x = op.b; y = op.a + op.cin; yo = op.a;
                end
                MODE_LLS: if (op.b < 64) begin
                    t = {32'd0, op.a} << op.b;
                    r.res = t[31:0];
                    r.cy = t[32];
                end
                MODE_RLS: if (op.b < 64) begin
                    t = {31'd0, op.a, 1'b0} >> op.b;
                    r.cy = t[0];
                    r.res = t[32:1];
                end
                MODE_ARS: begin
                    if (op.b < 64) begin
                        t = $signed({{31{op.a[31]}}, op.a, 1'b0}) >>> op.b;
                        r.cy = t[0];
                        r.res = t[32:1];
                    end else begin
                        r.res = {32{op.a[31]}};
                        r.cy = op.a[31];
                    end
                end
                MODE_ROTL, MODE_ROTR: begin
                    s = {27'd0, op.b[4:0]};
                    if (s == 0) r.res = op.a;
                    else if (op.mode == MODE_ROTL) r.res = (op.a << s) | (op.a >> (32 - s));
                    else r.res = (op.a >> s) | (op.a << (32 - s));
                end
                MODE_MUL, MODE_SMUL: begin
                    if (op.mode == MODE_MUL) t = {32'd0, op.a} * {32'd0, op.b};
                    else t = {{32{op.a[31]}}, op.a} * {{32{op.b[31]}}, op.b};
                    r.res = t[31:0];
                    r.hi = t[63:32];
                    r.wh = 1;
                end
                MODE_DIV, MODE_SDIV: begin
                    if (op.b == 0) begin
                        r.wr = 0;
                        r.dz = 1;
                    end else if (op.mode == MODE_DIV) begin
                        r.res = op.a / op.b;
                        r.hi = op.a % op.b;
                        r.wh = 1;
                    end else begin
                        ma = op.a[31] ? -op.a : op.a;
                        mb = op.b[31] ? -op.b : op.b;
                        q = ma / mb;
                        rm = ma % mb;
                        if (op.a[31] != op.b[31]) q = -q;
                        if (op.a[31]) rm = -rm;
                        r.res = q;
                        r.hi = rm;
                        r.wh = 1;
                    end
                end
                default: begin
                    r.wr = 0;
                    r.cy = op.cin;
                    r.ov = op.oin;
                end
            endcase
            if (use_sub) begin
                r.res = x - y;
                r.cy = x < y;
                if (x[31] != yo[31]) r.ov = r.res[31] != x[31];
                else r.ov = op.oin;
            end
            return r;
        endfunction

        function void note_op(t_op op);
            pending.push_back(compute(op));
        endfunction

        function void check_result(t_res got);
            t_res e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.res !== e.res) $display("%0t: result exp %h got %h", $time, e.res, got.res);
            if (got.hi !== e.hi) $display("%0t: high exp %h got %h", $time, e.hi, got.hi);
            if (got.cy !== e.cy) $display("%0t: carry exp %b got %b", $time, e.cy, got.cy);
            if (got.ov !== e.ov) $display("%0t: ovf exp %b got %b", $time, e.ov, got.ov);
            if (got.wr !== e.wr) $display("%0t: wr exp %b got %b", $time, e.wr, got.wr);
            if (got.wh !== e.wh) $display("%0t: wh exp %b got %b", $time, e.wh, got.wh);
            if (got.dz !== e.dz) $display("%0t: dz exp %b got %b", $time, e.dz, got.dz);
            if (got !== e) errors++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;

    alu_with_flags_mul_div_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),   // mode, operand_a, operand_b, carry_in, overflow_in
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)    // result, high_result, carry_out, overflow_out,
                                        // writes_result, writes_high, divide_by_zero
    );

    always #5 i_clk = ~i_clk;

    alu_scoreboard board = new();
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  recv_hold;
    bit  sending_done;
    int  cycle_count;
    int  sent;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(t_res'({m_axis_tdata[31:0], m_axis_tdata[63:32],
                m_axis_tdata[64], m_axis_tdata[65], m_axis_tdata[66],
                m_axis_tdata[67], m_axis_tdata[68]}));
        m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_op(t_op op);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, op.oin, op.cin, op.b, op.a, op.mode};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_op(op);
        sent++;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(70);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random(int n);
        t_op op;
        repeat (n) begin
            op.mode = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 19))
                                                : 5'($urandom_range(18));
            op.a = rand_word();
            op.b = rand_word();
            op.cin = 1'($urandom_range(1));
            op.oin = 1'($urandom_range(1));
            send_op(op);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_op op;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int m = 0; m < 19; m++) begin
            op.mode = m[4:0];
            op.a = (m % 2) ? 32'h8000_0000 : 32'hFFFF_FFFF;
            op.b = (m % 3 == 0) ? 32'hFFFF_FFFF : 32'd0;
            op.cin = 1;
            op.oin = m[0];
            send_op(op);
        end
        send_op('{MODE_SDIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0});
        send_op('{MODE_ARS, 32'h8000_0001, 32'd64, 1'b0, 1'b0});
        send_op('{MODE_LLS, 32'hFFFF_FFFF, 32'd63, 1'b0, 1'b0});
        send_op('{MODE_ROTR, 32'h1234_5678, 32'd32, 1'b0, 1'b0});
        send_op('{MODE_RSB, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1});
        send_op('{5'd31, 32'h0, 32'h0, 1'b1, 1'b1});
        drain();
        send_idle_pct = 34;
        recv_idle_pct = 72;
        send_random(550);
        send_idle_pct = 72;
        recv_idle_pct = 34;
        send_random(550);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                recv_hold = 1;
                repeat (150) @(posedge i_clk);
                recv_hold = 0;
            end
            send_random(100);
        join
        send_random(550);
        sending_done = 1;
    end

    initial begin
        wait (sending_done);
        drain();
        repeat (60) @(posedge i_clk);
        $display("sent %0d items over all 19 operations, unused codes and edge operands", sent);
        $display("checked %0d results under varied backpressure", board.checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// ----- alu_with_flags_mul_div_unit.f -----
design/awfmd_pkg.sv
design/awfmd_div.sv
design/alu_with_flags_mul_div_unit.sv
verif/alu_with_flags_mul_div_unit_test.sv
